/* sv/two_source_wave_height_unit_defines.svh */
// Assertion macros for the two-source wave height unit.
// Depends on nothing; included by the files that assert.
`ifndef TWO_SOURCE_WAVE_HEIGHT_UNIT_DEFINES_SVH
`define TWO_SOURCE_WAVE_HEIGHT_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define TWH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TWH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TWH_ASSERT(lbl, clk, rst_n, prop, msg)
`define TWH_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/twh_pkg.sv */
// Shared constants, types and helpers for the wave height unit.
// Depends on nothing.
package twh_pkg;

  localparam int AMP_W    = 8;
  localparam int PHASE_W  = 16;
  localparam int HEIGHT_W = 17;
  localparam int THETA_W  = 24;
  localparam int CFG_IDX_W = 3;
  localparam int HORNER_STEPS = 5;

  // distance (Q.8) to angle in 2^-24 turn, scaled by 2^16
  localparam logic [26:0] KTURN = 27'd68356528;

  // odd polynomial for sin(pi/2*z), Q30
  localparam logic signed [31:0] C1  = 32'sd1686629713;
  localparam logic signed [31:0] C3  = -32'sd693598668;
  localparam logic signed [31:0] C5  = 32'sd85569306;
  localparam logic signed [31:0] C7  = -32'sd5026995;
  localparam logic signed [31:0] C9  = 32'sd172272;
  localparam logic signed [31:0] C11 = -32'sd3864;

  typedef logic signed [31:0] coef_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_A_X = 3'd0,
    CFG_SRC_A_Y = 3'd1,
    CFG_SRC_B_X = 3'd2,
    CFG_SRC_B_Y = 3'd3,
    CFG_AMP_A   = 3'd4,
    CFG_AMP_B   = 3'd5
  } cfg_idx_t;

  // Horner coefficient added after multiply step n
  function automatic coef_t horner_coef(int n);
    coef_t c;
    unique case (n)
      0:       c = C9;
      1:       c = C7;
      2:       c = C5;
      3:       c = C3;
      default: c = C1;
    endcase
    return c;
  endfunction

  function automatic int root_bits(int cb);
    return cb + 9;
  endfunction

  // register stages from input to lane product
  function automatic int lane_lat(int cb);
    return root_bits(cb) + 18;
  endfunction

endpackage

/* sv/twh_sqrt_pipe.sv */
// Pipelined restoring square root, one root bit per stage, with side tag.
// Depends on nothing.
module twh_sqrt_pipe #(
  parameter int RB    = 21,
  parameter int TAG_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [2*RB-1:0]   in_rad,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_vld,
  output logic [RB-1:0]     out_root,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int RW = RB + 1;

  logic [RB-1:0]    vld_r;
  logic [RW-1:0]    rem_r  [RB];
  logic [RB-1:0]    root_r [RB];
  logic [2*RB-1:0]  rad_r  [RB];
  logic [TAG_W-1:0] tag_r  [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic             vld_p;
    logic [RW-1:0]    rem_p;
    logic [RB-1:0]    root_p;
    logic [2*RB-1:0]  rad_p;
    logic [TAG_W-1:0] tag_p;
    logic [RW+1:0]    rem_in;
    logic [RW+1:0]    trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_p  = in_vld;
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = in_rad;
      assign tag_p  = in_tag;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign tag_p  = tag_r[k-1];
    end

    assign rem_in = {rem_p, rad_p[2*RB-1 -: 2]};
    assign trial  = {1'b0, root_p, 2'b01};
    assign ge     = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? RW'(rem_in - trial) : RW'(rem_in);
      root_r[k] <= {root_p[RB-2:0], ge};
      rad_r[k]  <= {rad_p[2*RB-3:0], 2'b00};
      tag_r[k]  <= tag_p;
    end
  end

  assign out_vld  = vld_r[RB-1];
  assign out_root = root_r[RB-1];
  assign out_tag  = tag_r[RB-1];

endmodule

/* sv/twh_cos_pipe.sv */
// Pipelined cosine: folded angle in, Q30 value out via Horner evaluation.
// Depends on twh_pkg.
module twh_cos_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [23:0] in_s,
  output logic               out_vld,
  output logic signed [31:0] out_cos
);

  localparam int STEPS = twh_pkg::HORNER_STEPS;

  logic               vz_r;
  logic signed [31:0] z2_r;
  logic signed [23:0] sz_r;
  logic signed [47:0] sq;

  logic [STEPS-1:0]   vm_r;
  logic [STEPS-1:0]   va_r;
  logic signed [63:0] m_r   [STEPS];
  logic signed [31:0] z2m_r [STEPS];
  logic signed [23:0] sm_r  [STEPS];
  logic signed [31:0] p_r   [STEPS];
  logic signed [31:0] z2a_r [STEPS];
  logic signed [23:0] sa_r  [STEPS];

  logic               vp_r;
  logic signed [55:0] ps_r;

  assign sq = in_s * in_s;

  // z^2 in Q30 is s^2 / 2^14
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vz_r <= 1'b0;
    end else begin
      vz_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    z2_r <= sq[45:14];
    sz_r <= in_s;
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_horner
    logic               vin;
    logic signed [31:0] pin;
    logic signed [31:0] z2in;
    logic signed [23:0] sin_;

    if (j == 0) begin : g_first
      assign vin  = vz_r;
      assign pin  = twh_pkg::C11;
      assign z2in = z2_r;
      assign sin_ = sz_r;
    end else begin : g_next
      assign vin  = va_r[j-1];
      assign pin  = p_r[j-1];
      assign z2in = z2a_r[j-1];
      assign sin_ = sa_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vm_r[j] <= 1'b0;
        va_r[j] <= 1'b0;
      end else begin
        vm_r[j] <= vin;
        va_r[j] <= vm_r[j];
      end
    end

    always_ff @(posedge clk) begin
      m_r[j]   <= pin * z2in;
      z2m_r[j] <= z2in;
      sm_r[j]  <= sin_;
      p_r[j]   <= twh_pkg::horner_coef(j) + $signed(m_r[j][61:30]);
      z2a_r[j] <= z2m_r[j];
      sa_r[j]  <= sm_r[j];
    end
  end

  // p*z >> 30 with z = s*256 equals p*s >> 22
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else begin
      vp_r <= va_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    ps_r <= p_r[STEPS-1] * sa_r[STEPS-1];
  end

  assign out_vld = vp_r;
  assign out_cos = $signed(ps_r[53:22]);

endmodule

/* sv/twh_lane.sv */
// One source lane: distance, phase angle, cosine and amplitude product.
// Depends on twh_pkg, twh_sqrt_pipe and twh_cos_pipe.
module twh_lane #(
  parameter int CB = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  logic signed [CB-1:0]            point_x,
  input  logic signed [CB-1:0]            point_y,
  input  logic [twh_pkg::PHASE_W-1:0]     phase,
  input  logic signed [CB-1:0]            src_x,
  input  logic signed [CB-1:0]            src_y,
  input  logic signed [twh_pkg::AMP_W-1:0] amp,
  output logic                            out_vld,
  output logic signed [39:0]              out_term
);

  localparam int RB = twh_pkg::root_bits(CB);
  localparam int PW = twh_pkg::PHASE_W;

  logic                 v1_r, v2_r, v3_r, vk_r, vs_r, vt_r;
  logic signed [CB:0]   dx_r, dy_r;
  logic [PW-1:0]        ph1_r, ph2_r, ph3_r, phk_r;
  logic signed [2*CB+1:0] sqx_full, sqy_full;
  logic [2*CB-1:0]      sqx_r, sqy_r;
  logic [2*CB:0]        dsq_r;
  logic [2*RB-1:0]      rad;
  logic                 sq_vld;
  logic [RB-1:0]        root;
  logic [PW-1:0]        sq_ph;
  logic [RB+26:0]       kp_full;
  logic [23:0]          kp_r;
  logic [23:0]          theta, ang;
  logic signed [23:0]   s_nxt, s_r;
  logic                 cos_vld;
  logic signed [31:0]   cos_q30;
  logic signed [39:0]   term_r;

  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vk_r <= 1'b0;
      vs_r <= 1'b0;
      vt_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vk_r <= sq_vld;
      vs_r <= vk_r;
      vt_r <= cos_vld;
    end
  end

  always_ff @(posedge clk) begin
    dx_r  <= (CB+1)'(point_x) - (CB+1)'(src_x);
    dy_r  <= (CB+1)'(point_y) - (CB+1)'(src_y);
    ph1_r <= phase;
    sqx_r <= sqx_full[2*CB-1:0];
    sqy_r <= sqy_full[2*CB-1:0];
    ph2_r <= ph1_r;
    dsq_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
    ph3_r <= ph2_r;
  end

  // radicand is dsq * 2^16, root comes out as distance in Q.8
  assign rad = {1'b0, dsq_r, 16'h0000};

  twh_sqrt_pipe #(
    .RB    (RB),
    .TAG_W (PW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v3_r),
    .in_rad   (rad),
    .in_tag   (ph3_r),
    .out_vld  (sq_vld),
    .out_root (root),
    .out_tag  (sq_ph)
  );

  assign kp_full = root * twh_pkg::KTURN;

  always_ff @(posedge clk) begin
    kp_r  <= kp_full[39:16];
    phk_r <= sq_ph;
  end

  // quarter-turn shift turns cos into sin, then fold into [-1/4, 1/4] turn
  assign theta = kp_r + {phk_r, 8'h00};
  assign ang   = theta + 24'h400000;

  always_comb begin
    priority if (ang < 24'h400000) begin
      s_nxt = ang;
    end else if (ang < 24'hC00000) begin
      s_nxt = 24'h800000 - ang;
    end else begin
      s_nxt = ang;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
  end

  twh_cos_pipe u_cos (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vs_r),
    .in_s    (s_r),
    .out_vld (cos_vld),
    .out_cos (cos_q30)
  );

  always_ff @(posedge clk) begin
    term_r <= amp * cos_q30;
  end

  assign out_vld  = vt_r;
  assign out_term = term_r;

endmodule

/* sv/two_source_wave_height_unit.sv */
// Path from a start request to out_strobe: the lane pipelines, dominated by the square-root
// pipeline (COORD_BITS+9 stages) and the cosine pipeline, then the output register.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Reset (synchronous, rst_n low) clears all valid bits and loads the
// default source positions and amplitudes.
// Depends on twh_pkg, twh_lane and the assertion macro header.
`include "two_source_wave_height_unit_defines.svh"

module two_source_wave_height_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [COORD_BITS-1:0]         in_point_x,
  input  logic signed [COORD_BITS-1:0]         in_point_y,
  input  logic [twh_pkg::PHASE_W-1:0]          in_phase,
  // result channel
  output logic                                 out_strobe,
  output logic signed [COORD_BITS-1:0]         out_grid_x,
  output logic signed [COORD_BITS-1:0]         out_grid_y,
  output logic signed [twh_pkg::HEIGHT_W-1:0]  out_height,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [twh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_BITS-1:0]                cfg_data
);

  localparam int CB       = COORD_BITS;
  localparam int LANE_LAT = twh_pkg::lane_lat(COORD_BITS);
  localparam int AW       = twh_pkg::AMP_W;
  localparam int HW       = twh_pkg::HEIGHT_W;

  // configuration registers
  logic signed [CB-1:0] src_ax_r, src_ay_r, src_bx_r, src_by_r;
  logic signed [AW-1:0] amp_a_r, amp_b_r;

  // lanes see configuration directly: the user must change it only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_ax_r <= CB'(700);
      src_ay_r <= CB'(50);
      src_bx_r <= CB'(300);
      src_by_r <= CB'(500);
      amp_a_r  <= AW'(7);
      amp_b_r  <= AW'(7);
    end else if (cfg_valid && cfg_ready) begin
      unique case (twh_pkg::cfg_idx_t'(cfg_index))
        twh_pkg::CFG_SRC_A_X: src_ax_r <= cfg_data;
        twh_pkg::CFG_SRC_A_Y: src_ay_r <= cfg_data;
        twh_pkg::CFG_SRC_B_X: src_bx_r <= cfg_data;
        twh_pkg::CFG_SRC_B_Y: src_by_r <= cfg_data;
        twh_pkg::CFG_AMP_A:   amp_a_r  <= cfg_data[AW-1:0];
        twh_pkg::CFG_AMP_B:   amp_b_r  <= cfg_data[AW-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // two identical lanes, one per source
  logic               va, vb;
  logic signed [39:0] term_a, term_b;

  twh_lane #(.CB(CB)) u_lane_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .point_x  (in_point_x),
    .point_y  (in_point_y),
    .phase    (in_phase),
    .src_x    (src_ax_r),
    .src_y    (src_ay_r),
    .amp      (amp_a_r),
    .out_vld  (va),
    .out_term (term_a)
  );

  twh_lane #(.CB(CB)) u_lane_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .point_x  (in_point_x),
    .point_y  (in_point_y),
    .phase    (in_phase),
    .src_x    (src_bx_r),
    .src_y    (src_by_r),
    .amp      (amp_b_r),
    .out_vld  (vb),
    .out_term (term_b)
  );

  // grid echo rides a delay line matched to the lanes
  logic [LANE_LAT-1:0]  vld_sr;
  logic signed [CB-1:0] gx_sr [LANE_LAT];
  logic signed [CB-1:0] gy_sr [LANE_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_sr <= '0;
    end else begin
      vld_sr <= {vld_sr[LANE_LAT-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    gx_sr[0] <= in_point_x;
    gy_sr[0] <= in_point_y;
    for (int k = 1; k < LANE_LAT; k++) begin
      gx_sr[k] <= gx_sr[k-1];
      gy_sr[k] <= gy_sr[k-1];
    end
  end

  // sum in Q30, round half up to Q8, clamp to 17 bits
  logic signed [40:0] sum_q30;
  logic signed [40:0] sum_rnd;
  logic signed [18:0] h_wide;
  logic signed [HW-1:0] h_nxt;

  assign sum_q30 = 41'(term_a) + 41'(term_b);
  assign sum_rnd = sum_q30 + 41'sd2097152;
  assign h_wide  = $signed(sum_rnd[40:22]);

  always_comb begin
    priority if (h_wide > 19'sd65535) begin
      h_nxt = 17'sd65535;
    end else if (h_wide < -19'sd65536) begin
      h_nxt = -17'sd65536;
    end else begin
      h_nxt = h_wide[HW-1:0];
    end
  end

  logic                 out_vld_r;
  logic signed [CB-1:0] out_gx_r, out_gy_r;
  logic signed [HW-1:0] out_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_sr[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_gx_r <= gx_sr[LANE_LAT-1];
    out_gy_r <= gy_sr[LANE_LAT-1];
    out_h_r  <= h_nxt;
  end

  assign out_strobe = out_vld_r;
  assign out_grid_x = out_gx_r;
  assign out_grid_y = out_gy_r;
  assign out_height = out_h_r;

  // lane valids must line up with the grid delay line
  `TWH_ASSERT(a_lane_a_align, clk, rst_n, va == vld_sr[LANE_LAT-1], "lane A out of step")
  `TWH_ASSERT(a_lane_b_align, clk, rst_n, va == vb, "lanes out of step")
  `TWH_ASSERT(a_req_to_result, clk, rst_n, start |-> ##(LANE_LAT+1) out_strobe, "result missing")
  `TWH_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_strobe, "strobe after reset")

endmodule
